FILE: sv/min_tracking_stack_defines.svh
// ----------------------------------------------------------------------------
// Min tracking stack assertion macros
// Concurrent check helpers; they compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

`ifndef SYNTHESIS
// Checks an implication within the same cycle.
`define MST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Checks a consequence in the cycle after its antecedent.
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/minstk_pkg.sv
// ----------------------------------------------------------------------------
// Min tracking stack package
// Widths, command and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package minstk_pkg;

  // Field widths of the item and result.
  localparam int VALUE_W  = 32;
  localparam int DEPTH_W  = 9;
  localparam int STATUS_W = 2;

  // Default number of entries.
  localparam int STACK_DEPTH_DEF = 256;

  // Value reported for top and minimum when the stack is empty.
  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -VALUE_W'(1);

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // One stored level: its value and the minimum at or below it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] min;
  } entry_t;

endpackage

FILE: sv/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// Min tracking stack
// LIFO of signed values that reports top, running minimum and depth per item.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                         Direction
//  -------   --------------------------------------------  ---------
//  input     in_valid, in_stall, in_cmd, in_push_value     to block
//  result    out_valid, out_stall, out_top_value,          from block
//            out_min_value, out_depth, out_status
//
//  One item per cycle; each result appears in the cycle after its item.
//  The top entry lives in registers and the entry below it is read ahead
//  from a one-port-write, one-port-read memory, so a pop never waits.
//  A push forwards the entry it writes, covering the same-address read.
//  Reset empties the stack at once; the memory needs no clearing pass.
//  While a result is stalled, no new item is taken.
//
`timescale 1ns / 1ps
`include "min_tracking_stack_defines.svh"

module min_tracking_stack #(
  parameter int STACK_DEPTH = minstk_pkg::STACK_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_cmd,
  input  logic signed [minstk_pkg::VALUE_W-1:0]  in_push_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [minstk_pkg::VALUE_W-1:0]  out_top_value,
  output logic signed [minstk_pkg::VALUE_W-1:0]  out_min_value,
  output logic        [minstk_pkg::DEPTH_W-1:0]  out_depth,
  output logic        [minstk_pkg::STATUS_W-1:0] out_status
);

  import minstk_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  // Storage for every level below the top.
  entry_t mem [STACK_DEPTH];

  logic [CW-1:0]              count_r, count_nxt;
  logic signed [VALUE_W-1:0]  top_val_r, top_val_nxt;
  logic signed [VALUE_W-1:0]  top_min_r, top_min_nxt;
  entry_t                     rd_data_r;
  entry_t                     fwd_data_r;
  logic                       fwd_r;
  entry_t                     below;
  logic                       in_accept;
  logic                       is_push;
  logic                       is_full;
  logic                       is_empty;
  logic                       mem_we;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [CW-1:0]              rd_count;
  status_t                    status_nxt;

  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_top_r;
  logic signed [VALUE_W-1:0]  out_min_r;
  logic [DEPTH_W-1:0]         out_depth_r;
  status_t                    out_status_r;

  // Handshake: take an item unless a finished result is held back.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign is_push   = (in_cmd == CMD_PUSH);
  assign is_full   = (count_r == FULL_COUNT);
  assign is_empty  = (count_r == '0);

  // The entry just below the top, from the forward path or the memory.
  assign below = fwd_r ? fwd_data_r : rd_data_r;

  // Next stack state for the accepted item.
  always_comb begin
    count_nxt   = count_r;
    top_val_nxt = top_val_r;
    top_min_nxt = top_min_r;
    status_nxt  = ST_DONE;
    mem_we      = 1'b0;
    if (in_accept) begin
      if (is_push) begin
        if (is_full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          count_nxt   = count_r + CW'(1);
          top_val_nxt = in_push_value;
          if (is_empty || (in_push_value < top_min_r)) begin
            top_min_nxt = in_push_value;
          end
          mem_we = ~is_empty;
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          count_nxt   = count_r - CW'(1);
          top_val_nxt = below.value;
          top_min_nxt = below.min;
        end
      end
    end
  end

  // The old top goes to the level it occupies; the read looks one below the new top.
  assign wr_addr  = AW'(count_r - CW'(1));
  assign rd_count = count_nxt - CW'(2);
  assign rd_addr  = rd_count[AW-1:0];

  // Entry memory, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{value: top_val_r, min: top_min_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  // A push writes the very entry that is read in the same cycle, so forward it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_data_r <= '{value: top_val_r, min: top_min_r};
    end
  end

  // Stack pointer and top registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_min_r <= top_min_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_accept | in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_top_r    <= (count_nxt == '0) ? EMPTY_VALUE : top_val_nxt;
      out_min_r    <= (count_nxt == '0) ? EMPTY_VALUE : top_min_nxt;
      out_depth_r  <= DEPTH_W'(count_nxt);
      out_status_r <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_min_value = out_min_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;

  // Checks.
  `MST_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_COUNT,
    "stack count exceeds its depth")
  `MST_ASSERT_NEXT(a_push_grows, clk, rst_n, in_accept && is_push && !is_full,
    count_r == $past(count_r) + CW'(1), "accepted push did not grow the stack")
  `MST_ASSERT_NEXT(a_pop_empty, clk, rst_n, in_accept && !is_push && is_empty,
    out_valid && out_status == ST_POP_EMPTY && out_depth == '0,
    "pop on empty stack not flagged")

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Min tracking stack testbench
// Sends push and pop items through the input channel, predicts top, running
// minimum, depth and status for each one with a shadow stack, and checks
// every result in order. The run goes through an empty stack, a full stack,
// a long result stall and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import minstk_pkg::*;

  localparam int STK_DEPTH    = STACK_DEPTH_DEF;
  localparam int ITEM_TARGET  = 1300;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 900;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 8;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One planned item, or a marker that waits for all results to come back.
  typedef struct {
    logic                      pause;
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
  } stack_op_t;

  // What the stack reports after one item.
  typedef struct {
    logic signed [VALUE_W-1:0] top;
    logic signed [VALUE_W-1:0] low;
    logic        [DEPTH_W-1:0] depth;
    status_t                   st;
  } stack_view_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_cmd = CMD_PUSH;
  logic signed [VALUE_W-1:0] in_push_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_top_value;
  logic signed [VALUE_W-1:0] out_min_value;
  logic        [DEPTH_W-1:0] out_depth;
  logic       [STATUS_W-1:0] out_status;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];
  stack_op_t   next_op;
  stack_view_t want_view;

  // Shadow copy of the stack contents.
  logic signed [VALUE_W-1:0] shadow_values [STK_DEPTH];
  logic signed [VALUE_W-1:0] shadow_mins   [STK_DEPTH];
  int                        shadow_count = 0;

  logic in_taken = 1'b0;
  int   ops_sent = 0;
  int   results_seen = 0;
  int   mismatch_count = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   quiet_cycles = 0;
  int   plan_depth = 0;

  min_tracking_stack #(
    .STACK_DEPTH(STK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_top_value(out_top_value),
    .out_min_value(out_min_value),
    .out_depth    (out_depth),
    .out_status   (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one push or pop to the shadow stack and returns what it shows.
  function automatic stack_view_t step_stack(logic cmd, logic signed [VALUE_W-1:0] v);
    stack_view_t               view;
    logic signed [VALUE_W-1:0] m;
    view.st = ST_DONE;
    if (cmd == CMD_PUSH) begin
      if (shadow_count >= STK_DEPTH) begin
        view.st = ST_PUSH_FULL;
      end else begin
        m = v;
        // Only a strictly smaller value takes over the minimum.
        if (shadow_count > 0 && !(v < shadow_mins[shadow_count-1])) begin
          m = shadow_mins[shadow_count-1];
        end
        shadow_values[shadow_count] = v;
        shadow_mins[shadow_count] = m;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        view.st = ST_POP_EMPTY;
      end else begin
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      view.top = shadow_values[shadow_count-1];
      view.low = shadow_mins[shadow_count-1];
    end else begin
      view.top = EMPTY_VALUE;
      view.low = EMPTY_VALUE;
    end
    view.depth = DEPTH_W'(shadow_count);
    return view;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Adds one item to the plan and tracks the depth it will leave.
  task automatic plan_op(logic cmd, logic signed [VALUE_W-1:0] v);
    stack_op_t op;
    op.pause = 1'b0;
    op.cmd = cmd;
    op.value = v;
    pending_ops.push_back(op);
    if (cmd == CMD_PUSH && plan_depth < STK_DEPTH) begin
      plan_depth++;
    end else if (cmd == CMD_POP && plan_depth > 0) begin
      plan_depth--;
    end
  endtask

  // Picks a value: extremes, small values that often tie, or anything.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: v = VAL_MAX;
      1: v = VAL_MIN;
      2: v = '0;
      3: v = EMPTY_VALUE;
      4, 5, 6: begin
        v = $urandom_range(16);
        v = v - 8;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Plans the stimulus, applies reset and waits for the end of the run.
  initial begin
    stack_op_t marker;
    int        walk_len;
    int        push_pct;
    int        extra;
    marker.pause = 1'b1;
    marker.cmd = CMD_PUSH;
    marker.value = '0;

    // Directed: pops on empty, extremes, ties with the minimum, -1 as data.
    plan_op(CMD_POP, $urandom());
    plan_op(CMD_PUSH, VAL_MAX);
    plan_op(CMD_PUSH, VAL_MAX);
    plan_op(CMD_PUSH, 32'sd5);
    plan_op(CMD_PUSH, 32'sd5);
    plan_op(CMD_PUSH, VAL_MIN);
    plan_op(CMD_PUSH, VAL_MIN);
    plan_op(CMD_PUSH, '0);
    plan_op(CMD_PUSH, EMPTY_VALUE);
    repeat (4) plan_op(CMD_POP, $urandom());
    plan_op(CMD_PUSH, 32'sd3);
    repeat (6) plan_op(CMD_POP, $urandom());

    // Random walks, with at least one fill past full and one drain past empty.
    while (pending_ops.size() < ITEM_TARGET) begin
      case ((pending_ops.size() < 400) ? 0 : $urandom_range(9))
        7, 8: begin
          while (plan_depth < STK_DEPTH) plan_op(CMD_PUSH, pick_value());
          extra = $urandom_range(3, 1);
          repeat (extra) plan_op(CMD_PUSH, pick_value());
        end
        9: begin
          while (plan_depth > 0) plan_op(CMD_POP, $urandom());
          extra = $urandom_range(3, 1);
          repeat (extra) plan_op(CMD_POP, $urandom());
          pending_ops.push_back(marker);
        end
        default: begin
          walk_len = $urandom_range(60, 10);
          push_pct = $urandom_range(75, 35);
          repeat (walk_len) begin
            if ($urandom_range(99) < push_pct) begin
              plan_op(CMD_PUSH, pick_value());
            end else begin
              plan_op(CMD_POP, $urandom());
            end
          end
        end
      endcase
      if (pending_ops.size() >= 400 && pending_ops.size() < 700 && plan_depth < STK_DEPTH) begin
        while (plan_depth < STK_DEPTH) plan_op(CMD_PUSH, pick_value());
        plan_op(CMD_PUSH, pick_value());
        pending_ops.push_back(marker);
        while (plan_depth > 0) plan_op(CMD_POP, $urandom());
        plan_op(CMD_POP, $urandom());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to go in and its result to come back.
    while (pending_ops.size() > 0 || in_valid || expected_views.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Item driver: offers the next planned item, idles at random, and holds
  // back at a pause marker until every result is in.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_ops.size() > 0 && pending_ops[0].pause) begin
        in_valid <= 1'b0;
        if (expected_views.size() == 0) begin
          void'(pending_ops.pop_front());
        end
      end else if (pending_ops.size() > 0 &&
                   ((ops_sent >= CALM_FROM && ops_sent < CALM_TO) ||
                    $urandom_range(99) >= IDLE_PCT)) begin
        next_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_cmd <= next_op.cmd;
        in_push_value <= next_op.value;
        ops_sent <= ops_sent + 1;
      end else begin
        in_valid <= 1'b0;
        in_cmd <= 1'($urandom_range(1));
        in_push_value <= $urandom();
      end
    end
  end

  // Result stall: random, quiet for a stretch, and one long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: checks each accepted result, then predicts each accepted item.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_views.size() == 0) begin
        $display("%0t: result with nothing expected: top %0h min %0h depth %0d status %0d",
                 $time, out_top_value, out_min_value, out_depth, out_status);
        mismatch_count++;
      end else begin
        want_view = expected_views.pop_front();
        check_field("top_value", want_view.top, out_top_value);
        check_field("min_value", want_view.low, out_min_value);
        check_field("depth", VALUE_W'(want_view.depth), VALUE_W'(out_depth));
        check_field("status", VALUE_W'(want_view.st), VALUE_W'(out_status));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_views.push_back(step_stack(in_cmd, in_push_value));
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item or result accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
